// ----- design/boxcar_average_linear_calibrate_defines.svh -----
// assertion macros shared by the boxcar average design files
// expects a clock named clock and a reset named reset in the using module
`ifndef BOXCAR_AVERAGE_LINEAR_CALIBRATE_DEFINES_SVH
`define BOXCAR_AVERAGE_LINEAR_CALIBRATE_DEFINES_SVH

// condition must hold at every edge out of reset
`define BAL_ASSERT_HOLD(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BAL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- design/bal_pkg.sv -----
// shared widths, constants and controller/datapath command types
// no dependencies
package bal_pkg;

   localparam int SMP_W      = 10;
   localparam int DVD_W      = 20;
   localparam int DVS_W      = 10;
   localparam int CNT_W      = 5;
   localparam int DIFF_W     = 11;
   localparam int PROD_W     = 21;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SMP_W-1:0] FULL_SCALE = 10'd1023;
   localparam logic [SMP_W-1:0] REST_RESET = 10'd945;
   localparam logic [SMP_W-1:0] FULL_RESET = 10'd735;

   localparam logic REG_IDX_REST = 1'b0;
   localparam logic REG_IDX_FULL = 1'b1;

   typedef struct packed {
      logic take;
      logic update;
      logic avg_calc;
      logic div_start;
      logic map_calc;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic calib_err;
   } status_type;

endpackage

// ----- design/bal_ifs.sv -----
// valid/ready stream interfaces for the sample and result words
// depends on bal_pkg
interface bal_req_if;
   logic                       valid;
   logic                       ready;
   logic [bal_pkg::SMP_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bal_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bal_pkg::SMP_W-1:0]  average;
   logic [bal_pkg::SMP_W-1:0]  axis_value;
   logic                       calib_error;

   modport source (output valid, output average, output axis_value, output calib_error,
                   input ready);
   modport sink   (input valid, input average, input axis_value, input calib_error,
                   output ready);
endinterface

// ----- design/bal_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on bal_pkg and the assertion macro header
`include "boxcar_average_linear_calibrate_defines.svh"

module bal_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bal_pkg::DVD_W-1:0]  dividend,
   input  logic [bal_pkg::DVS_W-1:0]  divisor,
   output logic                       done,
   output logic [bal_pkg::DVD_W-1:0]  quotient
);

   localparam int DVD_W = bal_pkg::DVD_W;
   localparam int DVS_W = bal_pkg::DVS_W;
   localparam int CNT_W = bal_pkg::CNT_W;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DVS_W-1:0]   rem_ff;
   logic [DVS_W-1:0]   dvs_ff;
   logic [DVD_W-1:0]   quo_ff;

   logic [DVS_W:0]     shift;
   logic [DVS_W:0]     trial;
   logic               fits;
   logic [DVS_W-1:0]   rem_in;
   logic [DVD_W-1:0]   quo_in;

   assign shift  = {rem_ff, quo_ff[DVD_W-1]};
   assign trial  = shift - {1'b0, dvs_ff};
   assign fits   = shift >= {1'b0, dvs_ff};
   assign rem_in = fits ? trial[DVS_W-1:0] : shift[DVS_W-1:0];
   assign quo_in = {quo_ff[DVD_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `BAL_ASSERT_IMP(a_no_restart_busy, start, !busy_ff, "divider started while busy")

endmodule

// ----- design/bal_dpath.sv -----
// datapath: sample ring, running sum, linear map and output word register
// depends on bal_pkg, bal_div and the assertion macro header
`include "boxcar_average_linear_calibrate_defines.svh"

module bal_dpath #(
   parameter int WINDOW = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bal_pkg::cmd_type              cmd,
   output bal_pkg::status_type           status,
   input  logic [bal_pkg::SMP_W-1:0]     req_sample,
   input  logic [bal_pkg::SMP_W-1:0]     rest_level,
   input  logic [bal_pkg::SMP_W-1:0]     full_level,
   output logic [bal_pkg::SMP_W-1:0]     average,
   output logic [bal_pkg::SMP_W-1:0]     axis_value,
   output logic                          calib_error
);

   localparam int SMP_W   = bal_pkg::SMP_W;
   localparam int DVD_W   = bal_pkg::DVD_W;
   localparam int DVS_W   = bal_pkg::DVS_W;
   localparam int DIFF_W  = bal_pkg::DIFF_W;
   localparam int PROD_W  = bal_pkg::PROD_W;
   localparam int PTR_W   = $clog2(WINDOW);
   localparam int SUM_W   = SMP_W + PTR_W;
   localparam int SUM_MAX = 1023 * WINDOW;
   localparam int RCP_SH  = SUM_W + PTR_W;
   localparam int RCP_W   = SUM_W + 1;
   localparam int AVG_P_W = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'(((1 << RCP_SH) + WINDOW - 1) / WINDOW);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

   logic [SMP_W-1:0]  ring_mem [WINDOW];
   logic [WINDOW-1:0] ring_vld_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SMP_W-1:0]  sample_ff;
   logic [SMP_W-1:0]  rd_data_ff;
   logic              rd_vld_ff;
   logic [SMP_W-1:0]  avg_ff;
   logic [DVD_W-1:0]  num_mag_ff;
   logic              num_neg_ff;
   logic [DVS_W-1:0]  den_mag_ff;
   logic              den_neg_ff;
   logic              err_ff;
   logic [SMP_W-1:0]  average_ff;
   logic [SMP_W-1:0]  axis_ff;
   logic              error_ff;

   logic [SMP_W-1:0]          old_smp;
   logic [SUM_W-1:0]          sum_in;
   logic [AVG_P_W-1:0]        avg_prod;
   logic                      div_done;
   logic [DVD_W-1:0]          div_quo;
   logic [SMP_W-1:0]          avg_w;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  diff_ext;
   logic signed [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]         prod_abs;
   logic signed [DIFF_W-1:0]  den;
   logic [DIFF_W-1:0]         den_abs;
   logic [SMP_W-1:0]          axis_in;

   // ring memory, read on take, written on update
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rd_data_ff <= ring_mem[ptr_ff];
         rd_vld_ff  <= ring_vld_ff[ptr_ff];
         sample_ff  <= req_sample;
      end
      if (cmd.update) begin
         ring_mem[ptr_ff] <= sample_ff;
      end
   end

   assign old_smp = rd_vld_ff ? rd_data_ff : '0;
   assign sum_in  = sum_ff - SUM_W'(old_smp) + SUM_W'(sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         ptr_ff      <= '0;
         sum_ff      <= '0;
      end else if (cmd.update) begin
         ring_vld_ff[ptr_ff] <= 1'b1;
         ptr_ff              <= (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
         sum_ff              <= sum_in;
      end
   end

   // floor of sum / WINDOW by reciprocal multiply
   assign avg_prod = AVG_P_W'(sum_ff) * AVG_P_W'(RCP_MUL);
   assign avg_w    = avg_prod[RCP_SH +: SMP_W];

   bal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_mag_ff),
      .divisor  (den_mag_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // (avg - rest) * 1023 as shift and subtract
   assign diff     = $signed({1'b0, avg_ff}) - $signed({1'b0, rest_level});
   assign diff_ext = PROD_W'(diff);
   assign prod     = (diff_ext <<< SMP_W) - diff_ext;
   assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
   assign den      = $signed({1'b0, full_level}) - $signed({1'b0, rest_level});
   assign den_abs  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

   always_ff @(posedge clock) begin
      if (cmd.avg_calc) begin
         avg_ff <= avg_w;
      end
      if (cmd.map_calc) begin
         num_mag_ff <= prod_abs[DVD_W-1:0];
         num_neg_ff <= prod[PROD_W-1];
         den_mag_ff <= den_abs[DVS_W-1:0];
         den_neg_ff <= den[DIFF_W-1];
         err_ff     <= (den == '0);
      end
   end

   // truncated quotient, then clamp to 0..1023
   always_comb begin
      if (err_ff || div_quo == '0 || (num_neg_ff ^ den_neg_ff)) begin
         axis_in = '0;
      end else if (div_quo > DVD_W'(bal_pkg::FULL_SCALE)) begin
         axis_in = bal_pkg::FULL_SCALE;
      end else begin
         axis_in = div_quo[SMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         average_ff <= avg_ff;
         axis_ff    <= axis_in;
         error_ff   <= err_ff;
      end
   end

   assign status.div_done  = div_done;
   assign status.calib_err = (full_level == rest_level);
   assign average          = average_ff;
   assign axis_value       = axis_ff;
   assign calib_error      = error_ff;

   `BAL_ASSERT_HOLD(a_sum_in_range, 32'(sum_ff) <= SUM_MAX, "window sum out of range")

endmodule

// ----- design/bal_ctrl.sv -----
// controller state machine sequencing ring update, average, map divide and delivery
// depends on bal_pkg and the assertion macro header
`include "boxcar_average_linear_calibrate_defines.svh"

module bal_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bal_pkg::status_type   status,
   output bal_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVG_CALC,
      ST_MAP_CALC,
      ST_MAP_START,
      ST_MAP_WAIT,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_AVG_CALC;
         end
         ST_AVG_CALC: begin
            cmd.avg_calc = 1'b1;
            state_in     = ST_MAP_CALC;
         end
         ST_MAP_CALC: begin
            cmd.map_calc = 1'b1;
            state_in     = status.calib_err ? ST_DELIVER : ST_MAP_START;
         end
         ST_MAP_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_MAP_WAIT;
         end
         ST_MAP_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BAL_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && !rsp_ready, !cmd.load_out, "result overwritten")
   `BAL_ASSERT_IMP(a_done_when_waiting, status.div_done, state_ff == ST_MAP_WAIT, "divider done outside wait")

endmodule

// ----- design/boxcar_average_linear_calibrate.sv -----
// top level: csr registers, controller and datapath of the boxcar average
// depends on bal_pkg, bal_ifs, bal_ctrl and bal_dpath
//
//   channel   direction  protocol      payload
//   req_chan  in         valid/ready   sample[9:0]
//   rsp_chan  out        valid/ready   average[9:0], axis_value[9:0], calib_error
//   csr_*     in         apb, 32 bit   rest_level @ 0x0, full_level @ 0x4
//
// a new sample is accepted only once the previous word is loaded into the output register
// the map is a 20-step restoring divide, skipped when the levels are equal; the average is a multiply
// the result is loaded after the map divide, or straight after the map step with equal levels
// reset is synchronous: ring valid bits, pointer and sum clear, levels go to 945 and 735
// a finished word waits in the output register while the next sample is taken
// a stalled result only blocks delivery of the following word
module boxcar_average_linear_calibrate #(
   parameter int WINDOW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   bal_req_if.sink                          req_chan,
   bal_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bal_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bal_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bal_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int SMP_W = bal_pkg::SMP_W;
   localparam int DATA_W = bal_pkg::CSR_DATA_W;

   logic [SMP_W-1:0]     rest_ff;
   logic [SMP_W-1:0]     full_ff;
   logic                 csr_wr;
   bal_pkg::cmd_type     cmd;
   bal_pkg::status_type  status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= bal_pkg::REST_RESET;
         full_ff <= bal_pkg::FULL_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            bal_pkg::REG_IDX_REST: rest_ff <= csr_pwdata[SMP_W-1:0];
            bal_pkg::REG_IDX_FULL: full_ff <= csr_pwdata[SMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         bal_pkg::REG_IDX_REST: csr_prdata = DATA_W'(rest_ff);
         bal_pkg::REG_IDX_FULL: csr_prdata = DATA_W'(full_ff);
         default:               csr_prdata = '0;
      endcase
   end

   bal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bal_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_chan.sample),
      .rest_level  (rest_ff),
      .full_level  (full_ff),
      .average     (rsp_chan.average),
      .axis_value  (rsp_chan.axis_value),
      .calib_error (rsp_chan.calib_error)
   );

endmodule

// ----- dv/boxcar_average_linear_calibrate_tb.sv -----
// self-checking bench for the boxcar average with linear level calibration
// depends on bal_pkg, bal_ifs and the boxcar_average_linear_calibrate top level
`timescale 1ns / 1ps

module boxcar_average_linear_calibrate_tb;

   localparam int SMP_W          = bal_pkg::SMP_W;
   localparam int CSR_ADDR_W     = bal_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W     = bal_pkg::CSR_DATA_W;
   localparam int WINDOW         = 8;
   localparam int SUM_W          = SMP_W + $clog2(WINDOW);
   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 106;

   typedef struct packed {
      logic [SMP_W-1:0] average;
      logic [SMP_W-1:0] axis_value;
      logic             calib_error;
   } level_word_type;

   typedef struct packed {
      logic [SMP_W-1:0] sample;
      logic             pinned;
      level_word_type   want;
   } sample_item_type;

   typedef enum logic [1:0] {ROW_WORD, ROW_SET_REST, ROW_SET_FULL} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [31:0]      data;
      int               reps;
      logic             pinned;
      logic [SMP_W-1:0] want_avg;
      logic [SMP_W-1:0] want_axis;
      logic             want_err;
   } dir_row_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bal_req_if req_chan();
   bal_rsp_if rsp_chan();

   boxcar_average_linear_calibrate #(.WINDOW(WINDOW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [SMP_W-1:0] ring_mem [WINDOW];
   int               ring_ptr;
   logic [SUM_W-1:0] ring_sum;
   logic [SMP_W-1:0] rest_lvl;
   logic [SMP_W-1:0] full_lvl;

   sample_item_type sample_feed[$];
   level_word_type  expected_levels[$];
   dir_row_type     directed_rows[$];

   logic offering          = 1'b0;
   logic long_hold_pending = 1'b0;
   int   mismatches        = 0;
   int   words_sent        = 0;
   int   words_checked     = 0;
   int   level_writes      = 0;

   function automatic level_word_type calibrate_sample(input logic [SMP_W-1:0] smp);
      level_word_type res;
      int span;
      int q;
      ring_sum = ring_sum - SUM_W'(ring_mem[ring_ptr]) + SUM_W'(smp);
      ring_mem[ring_ptr] = smp;
      ring_ptr = (ring_ptr + 1) % WINDOW;
      res.average = SMP_W'(ring_sum / WINDOW);
      span = int'(full_lvl) - int'(rest_lvl);
      if (span == 0) begin
         res.axis_value  = '0;
         res.calib_error = 1'b1;
      end else begin
         q = ((int'(res.average) - int'(rest_lvl)) * int'(bal_pkg::FULL_SCALE)) / span;
         if (q < 0) q = 0;
         else if (q > int'(bal_pkg::FULL_SCALE)) q = int'(bal_pkg::FULL_SCALE);
         res.axis_value  = q[SMP_W-1:0];
         res.calib_error = 1'b0;
      end
      return res;
   endfunction

   task automatic drain_words();
      while (sample_feed.size() != 0 || offering || expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic idx, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_level(input logic idx, input logic [31:0] wdata);
      logic [31:0] rd;
      drain_words();
      csr_access(idx, 1'b1, wdata, rd);
      csr_access(idx, 1'b0, '0, rd);
      if (rd[SMP_W-1:0] !== wdata[SMP_W-1:0]) begin
         $error("level readback mismatch: expected %0d, got %0d",
                wdata[SMP_W-1:0], rd[SMP_W-1:0]);
         mismatches++;
      end
      if (idx == bal_pkg::REG_IDX_REST) rest_lvl = wdata[SMP_W-1:0];
      else full_lvl = wdata[SMP_W-1:0];
      level_writes++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : run_control
      dir_row_type     row;
      sample_item_type item;
      logic [31:0]  wdata;
      logic [SMP_W-1:0] lv_rest;
      logic [SMP_W-1:0] lv_full;
      logic [SMP_W-1:0] prev;
      int mode;
      int v;

      reset          = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      ring_ptr = 0;
      ring_sum = '0;
      rest_lvl = bal_pkg::REST_RESET;
      full_lvl = bal_pkg::FULL_RESET;

      // warm-up from reset with the inverted reset levels, then extremes
      directed_rows.push_back('{ROW_WORD, 32'd1023, 1, 1'b1, 10'd127, 10'd1023, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd1023, 7, 1'b1, 10'd1023, 10'd0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd0, 1, 1'b0, '0, '0, 1'b0});
      // equal levels, upper data bits set
      directed_rows.push_back('{ROW_SET_REST, 32'hFFFF_FE00, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_FULL, 32'h0000_0200, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd1023, 1, 1'b1, 10'd895, 10'd0, 1'b1});
      // identity map
      directed_rows.push_back('{ROW_SET_REST, 32'hFFFF_FC00, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_FULL, 32'h0000_03FF, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd0, 8, 1'b1, 10'd0, 10'd0, 1'b0});
      // fully inverted map
      directed_rows.push_back('{ROW_SET_REST, 32'h8000_03FF, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_FULL, 32'h7FFF_FC00, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd0, 1, 1'b1, 10'd0, 10'd1023, 1'b0});
      // unit span both ways, clamps at each end
      directed_rows.push_back('{ROW_SET_REST, 32'd0, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_FULL, 32'd1, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd1023, 1, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_REST, 32'd1, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_SET_FULL, 32'd0, 0, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'd1023, 1, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'h0000_0155, 1, 1'b0, '0, '0, 1'b0});
      directed_rows.push_back('{ROW_WORD, 32'h0000_02AA, 1, 1'b0, '0, '0, 1'b0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_WORD: begin
               for (int k = 0; k < row.reps; k++) begin
                  item.sample            = row.data[SMP_W-1:0];
                  item.pinned            = row.pinned && (k == row.reps - 1);
                  item.want.average      = row.want_avg;
                  item.want.axis_value   = row.want_axis;
                  item.want.calib_error  = row.want_err;
                  sample_feed.push_back(item);
               end
            end
            ROW_SET_REST: write_level(bal_pkg::REG_IDX_REST, row.data);
            default: write_level(bal_pkg::REG_IDX_FULL, row.data);
         endcase
      end

      prev = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               lv_rest = '0;
               lv_full = bal_pkg::FULL_SCALE;
            end
            2: begin
               lv_rest = bal_pkg::FULL_SCALE;
               lv_full = '0;
            end
            3: begin
               lv_rest = SMP_W'($urandom_range(0, 1023));
               lv_full = lv_rest;
            end
            4: begin
               lv_rest = 10'd100;
               lv_full = 10'd900;
            end
            5: begin
               lv_rest = SMP_W'($urandom_range(0, 1022));
               lv_full = lv_rest + 1'b1;
            end
            6: begin
               lv_full = SMP_W'($urandom_range(0, 1022));
               lv_rest = lv_full + 1'b1;
            end
            default: begin
               lv_rest = SMP_W'($urandom_range(0, 1023));
               lv_full = SMP_W'($urandom_range(0, 1023));
            end
         endcase
         wdata = $urandom;
         wdata[SMP_W-1:0] = lv_rest;
         write_level(bal_pkg::REG_IDX_REST, wdata);
         wdata = $urandom;
         wdata[SMP_W-1:0] = lv_full;
         write_level(bal_pkg::REG_IDX_FULL, wdata);
         if (phase == 4) long_hold_pending = 1'b1;

         for (int n = 0; n < PHASE_WORDS; n++) begin
            mode = $urandom_range(0, 9);
            case (mode)
               0, 1, 2: v = $urandom_range(0, 1023);
               3: v = $urandom_range(0, 1) ? 1023 : 0;
               4, 5: v = int'(lv_rest) + int'($urandom_range(0, 40)) - 20;
               6, 7: v = int'(lv_full) + int'($urandom_range(0, 40)) - 20;
               default: v = int'(prev);
            endcase
            if (v < 0) v = 0;
            else if (v > 1023) v = 1023;
            item.sample = v[SMP_W-1:0];
            item.pinned = 1'b0;
            item.want   = '0;
            sample_feed.push_back(item);
            prev = item.sample;
         end
      end

      drain_words();
      $display("checked %0d result words for %0d samples over %0d level writes",
               words_checked, words_sent, level_writes);
      $display("levels covered reset, equal, inverted, unit-span and full-range maps");
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin : sample_source
      sample_item_type cur;
      level_word_type  res;
      int burst_left;
      int gap_left;
      burst_left      = 0;
      gap_left        = 0;
      cur             = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      forever begin
         @(posedge clock);
         if (req_chan.valid && req_chan.ready) begin
            res = calibrate_sample(cur.sample);
            expected_levels.push_back(cur.pinned ? cur.want : res);
            words_sent++;
            offering = 1'b0;
         end
         if (!offering && !reset) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (sample_feed.size() > 0) begin
               cur = sample_feed.pop_front();
               offering = 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0) begin
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 3);
                     2: gap_left = $urandom_range(5, 20);
                     default: gap_left = $urandom_range(30, 80);
                  endcase
               end
            end
         end
         req_chan.valid <= offering;
         req_chan.sample <= offering ? cur.sample : SMP_W'($urandom);
      end
   end

   initial begin : result_sink
      level_word_type want;
      int seg_left;
      int hold_left;
      int stall_mode;
      logic rdy;
      seg_left       = 0;
      hold_left      = 0;
      stall_mode     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_levels.size() == 0) begin
               $error("result word with no sample pending");
               mismatches++;
            end else begin
               want = expected_levels.pop_front();
               words_checked++;
               if (rsp_chan.average !== want.average) begin
                  $error("average mismatch: expected %0d, got %0d",
                         want.average, rsp_chan.average);
                  mismatches++;
               end
               if (rsp_chan.axis_value !== want.axis_value) begin
                  $error("axis_value mismatch: expected %0d, got %0d",
                         want.axis_value, rsp_chan.axis_value);
                  mismatches++;
               end
               if (rsp_chan.calib_error !== want.calib_error) begin
                  $error("calib_error mismatch: expected %0b, got %0b",
                         want.calib_error, rsp_chan.calib_error);
                  mismatches++;
               end
            end
         end
         if (long_hold_pending) begin
            hold_left = HOLD_CYCLES;
            long_hold_pending = 1'b0;
         end
         if (seg_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            seg_left   = $urandom_range(20, 200);
         end
         seg_left--;
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = (seg_left % 4 == 0);
            default: rdy = ($urandom_range(0, 7) != 0);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end
         rsp_chan.ready <= rdy;
      end
   end

   initial begin : stall_watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_levels.size());
      $display("status: fail");
      $finish;
   end

endmodule
